/* sv/gpor_pkg.sv */
// Shared types, constants and saturating Q16.16 arithmetic for the order parameter rate block.
package gpor_pkg;

  localparam int QW = 32;
  localparam int DIV_LAT = QW + 2;
  localparam int CFG_N = 8;
  localparam int CFG_IDX_W = 4;
  localparam int DIMENSIONS_DEF = 3;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int LANES = 6;

  typedef logic signed [QW-1:0] q_t;

  localparam logic [2:0] CFG_INV_SOLID = 3'd0;
  localparam logic [2:0] CFG_INV_LIQUID = 3'd1;
  localparam logic [2:0] CFG_SOLID_REF = 3'd2;
  localparam logic [2:0] CFG_LIQUID_REF = 3'd3;
  localparam logic [2:0] CFG_MOBILITY = 3'd4;
  localparam logic [2:0] CFG_BARRIER = 3'd5;
  localparam logic [2:0] CFG_INTERACTION = 3'd6;
  localparam logic [2:0] CFG_GRADIENT = 3'd7;

  localparam q_t INV_SOLID_RST = 32'sd65536;
  localparam q_t INV_LIQUID_RST = 32'sd65536;
  localparam q_t SOLID_REF_RST = 32'sd0;
  localparam q_t LIQUID_REF_RST = 32'sd0;
  localparam q_t MOBILITY_RST = 32'sd65536;
  localparam q_t BARRIER_RST = 32'sd65536;
  localparam q_t INTERACTION_RST = 32'sd98304;
  localparam q_t GRADIENT_RST = 32'sd65536;

  localparam q_t Q_ZERO = 32'sd0;
  localparam q_t Q_TWO = 32'sd131072;
  localparam q_t Q_NEG_TWO = -32'sd131072;
  localparam q_t Q_NEG_HALF = -32'sd32768;
  localparam q_t Q_MAX = 32'h7FFF_FFFF;
  localparam q_t Q_MIN = 32'h8000_0000;
  localparam logic signed [47:0] FIT_HI = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] FIT_LO = 48'shFFFF_8000_0000;

  typedef struct packed {
    q_t   val;
    logic clip;
  } qres_t;

  typedef struct packed {
    q_t             mu;
    q_t             ns;
    q_t             nl;
    q_t [LANES-1:0] grad;
    q_t             p_ss;
    q_t             p_ll;
    q_t             muh;
    q_t             m2ns;
    q_t             mn2ns;
    q_t             m2nl;
    q_t             mn2nl;
    q_t             denom;
    logic           zero;
    logic           clip_a;
    logic           clip_b;
  } front_t;

  typedef struct packed {
    q_t m2ns;
    q_t mn2ns;
    q_t m2nl;
    q_t mn2nl;
    q_t denom;
  } dvd_t;

  typedef struct packed {
    q_t             ws;
    q_t             wl;
    q_t             mps;
    q_t             mpl;
    q_t [LANES-1:0] flux;
    logic           zero;
    logic           clip_a;
    logic           clip_b;
  } carry_t;

  typedef struct packed {
    q_t   inv_solid;
    q_t   inv_liquid;
    q_t   solid_ref;
    q_t   liquid_ref;
    q_t   barrier;
    q_t   neg_l;
    q_t   g2;
    q_t   coef;
    logic clip;
  } coeff_t;

  typedef struct packed {
    q_t             solid_rate;
    q_t             liquid_rate;
    q_t [LANES-1:0] flux;
    logic           zero;
    logic           sat;
  } result_t;

  function automatic qres_t qfit(input logic signed [47:0] v);
    qres_t r;
    if (v > FIT_HI) begin
      r.val = Q_MAX;
      r.clip = 1'b1;
    end else if (v < FIT_LO) begin
      r.val = Q_MIN;
      r.clip = 1'b1;
    end else begin
      r.val = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic qres_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return qfit($signed(p[63:16]));
  endfunction

  function automatic qres_t qadd(input q_t a, input q_t b);
    return qfit(48'(a) + 48'(b));
  endfunction

  function automatic qres_t qsub(input q_t a, input q_t b);
    return qfit(48'(a) - 48'(b));
  endfunction

endpackage

/* sv/gp_order_parameter_rates.sv */
// Top level: configuration registers, derived coefficients, front end, queue and back end.
// The path from an accepted point to its result runs through two ranks of 34-stage
// pipelined dividers in series.
// Throughput: one point per cycle; an output stall holds the back end, and the
// front end stalls once the queue is full.
// Reset: synchronous; it empties the pipelines and the queue and loads the
// configuration reset values; configuration writes are always ready.
module gp_order_parameter_rates #(
  parameter int DIMENSIONS = gpor_pkg::DIMENSIONS_DEF,
  parameter int QUEUE_DEPTH = gpor_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  gpor_pkg::q_t                      chem_potential,
  input  gpor_pkg::q_t                      solid_order,
  input  gpor_pkg::q_t                      liquid_order,
  input  gpor_pkg::q_t                      solid_grad_x,
  input  gpor_pkg::q_t                      solid_grad_y,
  input  gpor_pkg::q_t                      solid_grad_z,
  input  gpor_pkg::q_t                      liquid_grad_x,
  input  gpor_pkg::q_t                      liquid_grad_y,
  input  gpor_pkg::q_t                      liquid_grad_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output gpor_pkg::q_t                      solid_rate,
  output gpor_pkg::q_t                      liquid_rate,
  output gpor_pkg::q_t                      solid_flux_x,
  output gpor_pkg::q_t                      solid_flux_y,
  output gpor_pkg::q_t                      solid_flux_z,
  output gpor_pkg::q_t                      liquid_flux_x,
  output gpor_pkg::q_t                      liquid_flux_y,
  output gpor_pkg::q_t                      liquid_flux_z,
  output logic                              zero_denominator,
  output logic                              saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gpor_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  gpor_pkg::q_t                      cfg_data
);

  localparam int IW = $clog2(gpor_pkg::CFG_N);

  gpor_pkg::q_t cfg [gpor_pkg::CFG_N];
  gpor_pkg::qres_t neg_l, g2, lm, coef;
  gpor_pkg::coeff_t coeff;
  gpor_pkg::front_t f_item, q_head;
  gpor_pkg::result_t res;
  logic f_push, q_full, q_nonempty, b_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[gpor_pkg::CFG_INV_SOLID] <= gpor_pkg::INV_SOLID_RST;
      cfg[gpor_pkg::CFG_INV_LIQUID] <= gpor_pkg::INV_LIQUID_RST;
      cfg[gpor_pkg::CFG_SOLID_REF] <= gpor_pkg::SOLID_REF_RST;
      cfg[gpor_pkg::CFG_LIQUID_REF] <= gpor_pkg::LIQUID_REF_RST;
      cfg[gpor_pkg::CFG_MOBILITY] <= gpor_pkg::MOBILITY_RST;
      cfg[gpor_pkg::CFG_BARRIER] <= gpor_pkg::BARRIER_RST;
      cfg[gpor_pkg::CFG_INTERACTION] <= gpor_pkg::INTERACTION_RST;
      cfg[gpor_pkg::CFG_GRADIENT] <= gpor_pkg::GRADIENT_RST;
    end else if (cfg_valid && cfg_index < gpor_pkg::CFG_IDX_W'(gpor_pkg::CFG_N)) begin
      cfg[cfg_index[IW-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    neg_l <= gpor_pkg::qsub(gpor_pkg::Q_ZERO, cfg[gpor_pkg::CFG_MOBILITY]);
    g2 <= gpor_pkg::qmul(cfg[gpor_pkg::CFG_INTERACTION], gpor_pkg::Q_TWO);
    lm <= gpor_pkg::qmul(neg_l.val, cfg[gpor_pkg::CFG_BARRIER]);
    coef <= gpor_pkg::qmul(lm.val, cfg[gpor_pkg::CFG_GRADIENT]);
  end

  always_comb begin
    coeff.inv_solid = cfg[gpor_pkg::CFG_INV_SOLID];
    coeff.inv_liquid = cfg[gpor_pkg::CFG_INV_LIQUID];
    coeff.solid_ref = cfg[gpor_pkg::CFG_SOLID_REF];
    coeff.liquid_ref = cfg[gpor_pkg::CFG_LIQUID_REF];
    coeff.barrier = cfg[gpor_pkg::CFG_BARRIER];
    coeff.neg_l = neg_l.val;
    coeff.g2 = g2.val;
    coeff.coef = coef.val;
    coeff.clip = neg_l.clip | g2.clip | lm.clip | coef.clip;
  end

  gpor_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .chem_potential(chem_potential), .solid_order(solid_order),
    .liquid_order(liquid_order), .solid_grad_x(solid_grad_x),
    .solid_grad_y(solid_grad_y), .solid_grad_z(solid_grad_z),
    .liquid_grad_x(liquid_grad_x), .liquid_grad_y(liquid_grad_y),
    .liquid_grad_z(liquid_grad_z), .full(q_full), .push(f_push), .item(f_item)
  );

  gpor_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst), .push(f_push), .din(f_item), .full(q_full),
    .pop(b_pop), .dout(q_head), .nonempty(q_nonempty)
  );

  gpor_back #(.DIMENSIONS(DIMENSIONS)) u_back (
    .clk(clk), .rst(rst), .head(q_head), .head_valid(q_nonempty), .pop(b_pop),
    .coeff(coeff), .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign solid_rate = res.solid_rate;
  assign liquid_rate = res.liquid_rate;
  assign solid_flux_x = res.flux[0];
  assign solid_flux_y = res.flux[1];
  assign solid_flux_z = res.flux[2];
  assign liquid_flux_x = res.flux[3];
  assign liquid_flux_y = res.flux[4];
  assign liquid_flux_z = res.flux[5];
  assign zero_denominator = res.zero;
  assign saturated = res.sat;

endmodule

/* sv/gpor_div.sv */
// Pipelined saturating Q16.16 divider, one quotient bit per stage.
module gpor_div (
  input  logic           clk,
  input  logic           en,
  input  gpor_pkg::q_t   dividend,
  input  gpor_pkg::q_t   divisor,
  output gpor_pkg::qres_t quo
);

  localparam int STEPS = gpor_pkg::QW;

  logic [31:0] ua, ub, mag_a, mag_b;
  logic [31:0] rem [0:STEPS];
  logic [31:0] bits [0:STEPS];
  logic [31:0] quot [0:STEPS];
  logic [31:0] dv [0:STEPS];
  logic        neg [0:STEPS];
  logic        big [0:STEPS];
  logic [32:0] trial [1:STEPS];
  logic [32:0] diff [1:STEPS];
  logic        ge [1:STEPS];
  logic [31:0] qm;
  gpor_pkg::qres_t res;

  assign ua = dividend;
  assign ub = divisor;
  assign mag_a = ua[31] ? 32'd0 - ua : ua;
  assign mag_b = ub[31] ? 32'd0 - ub : ub;

  always_comb begin
    for (int k = 1; k <= STEPS; k++) begin
      trial[k] = {rem[k-1], bits[k-1][31]};
      ge[k] = trial[k] >= {1'b0, dv[k-1]};
      diff[k] = trial[k] - {1'b0, dv[k-1]};
    end
  end

  always_comb begin
    qm = quot[STEPS];
    if (neg[STEPS]) begin
      res.clip = big[STEPS] || (qm > 32'h8000_0000);
      res.val = res.clip ? gpor_pkg::Q_MIN : $signed(32'd0 - qm);
    end else begin
      res.clip = big[STEPS] || qm[31];
      res.val = res.clip ? gpor_pkg::Q_MAX : $signed(qm);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {16'd0, mag_a[31:16]};
      bits[0] <= {mag_a[15:0], 16'd0};
      quot[0] <= '0;
      dv[0] <= mag_b;
      neg[0] <= ua[31] ^ ub[31];
      big[0] <= {16'd0, mag_a[31:16]} >= mag_b;
      for (int k = 1; k <= STEPS; k++) begin
        rem[k] <= ge[k] ? diff[k][31:0] : trial[k][31:0];
        bits[k] <= {bits[k-1][30:0], 1'b0};
        quot[k] <= {quot[k-1][30:0], ge[k]};
        dv[k] <= dv[k-1];
        neg[k] <= neg[k-1];
        big[k] <= big[k-1];
      end
      quo <= res;
    end
  end

endmodule

/* sv/gpor_front.sv */
// Front end: accepts points, forms squares and scaled terms, and classifies the denominator.
module gpor_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gpor_pkg::q_t        chem_potential,
  input  gpor_pkg::q_t        solid_order,
  input  gpor_pkg::q_t        liquid_order,
  input  gpor_pkg::q_t        solid_grad_x,
  input  gpor_pkg::q_t        solid_grad_y,
  input  gpor_pkg::q_t        solid_grad_z,
  input  gpor_pkg::q_t        liquid_grad_x,
  input  gpor_pkg::q_t        liquid_grad_y,
  input  gpor_pkg::q_t        liquid_grad_z,
  input  logic                full,
  output logic                push,
  output gpor_pkg::front_t    item
);

  logic v1, v2, en;
  gpor_pkg::front_t f1, f2, f1_next, f2_next;
  gpor_pkg::qres_t r_ss, r_ll, r_muh, r_m2ns, r_mn2ns, r_m2nl, r_mn2nl, r_den;

  assign en = !v2 || !full;
  assign in_stall = !en;
  assign push = v2 && !full;
  assign item = f2;

  always_comb begin
    r_ss = gpor_pkg::qmul(solid_order, solid_order);
    r_ll = gpor_pkg::qmul(liquid_order, liquid_order);
    r_muh = gpor_pkg::qmul(gpor_pkg::Q_NEG_HALF, chem_potential);
    r_m2ns = gpor_pkg::qmul(gpor_pkg::Q_TWO, solid_order);
    r_mn2ns = gpor_pkg::qmul(gpor_pkg::Q_NEG_TWO, solid_order);
    r_m2nl = gpor_pkg::qmul(gpor_pkg::Q_TWO, liquid_order);
    r_mn2nl = gpor_pkg::qmul(gpor_pkg::Q_NEG_TWO, liquid_order);
    f1_next.mu = chem_potential;
    f1_next.ns = solid_order;
    f1_next.nl = liquid_order;
    f1_next.grad[0] = solid_grad_x;
    f1_next.grad[1] = solid_grad_y;
    f1_next.grad[2] = solid_grad_z;
    f1_next.grad[3] = liquid_grad_x;
    f1_next.grad[4] = liquid_grad_y;
    f1_next.grad[5] = liquid_grad_z;
    f1_next.p_ss = r_ss.val;
    f1_next.p_ll = r_ll.val;
    f1_next.muh = r_muh.val;
    f1_next.m2ns = r_m2ns.val;
    f1_next.mn2ns = r_mn2ns.val;
    f1_next.m2nl = r_m2nl.val;
    f1_next.mn2nl = r_mn2nl.val;
    f1_next.denom = gpor_pkg::Q_ZERO;
    f1_next.zero = 1'b0;
    f1_next.clip_a = r_ss.clip | r_ll.clip | r_muh.clip;
    f1_next.clip_b = r_m2ns.clip | r_mn2ns.clip | r_m2nl.clip | r_mn2nl.clip;
  end

  always_comb begin
    r_den = gpor_pkg::qadd(f1.p_ss, f1.p_ll);
    f2_next = f1;
    f2_next.denom = r_den.val;
    f2_next.zero = r_den.val == gpor_pkg::Q_ZERO;
    f2_next.clip_a = f1.clip_a | r_den.clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= f1_next;
      f2 <= f2_next;
    end
  end

endmodule

/* sv/gpor_fifo.sv */
// Short queue of classified points between the front end and the back end.
module gpor_fifo #(
  parameter int DEPTH = gpor_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  gpor_pkg::front_t din,
  output logic             full,
  input  logic             pop,
  output gpor_pkg::front_t dout,
  output logic             nonempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  gpor_pkg::front_t mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic do_push, do_pop;

  assign full = cnt == CW'(DEPTH);
  assign nonempty = cnt != '0;
  assign do_push = push && !full;
  assign do_pop = pop && nonempty;
  assign dout = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10: cnt <= cnt + 1'b1;
        2'b01: cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

endmodule

/* sv/gpor_back.sv */
// Back end: interpolation weights, their derivatives, grand potentials, the rate terms and the gradient fluxes.
module gpor_back #(
  parameter int DIMENSIONS = gpor_pkg::DIMENSIONS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gpor_pkg::front_t  head,
  input  logic              head_valid,
  output logic              pop,
  input  gpor_pkg::coeff_t  coeff,
  output logic              out_valid,
  input  logic              out_stall,
  output gpor_pkg::result_t res
);

  localparam int DL = gpor_pkg::DIV_LAT;
  localparam int N = 2 * DL + 7;

  logic [N-1:0] vs;
  logic en;

  gpor_pkg::front_t a;
  gpor_pkg::carry_t cv [1:DL];
  gpor_pkg::carry_t cv_next [1:DL];
  gpor_pkg::dvd_t mv [1:DL];
  gpor_pkg::carry_t ev [0:DL-1];

  gpor_pkg::q_t s1_t1, s1_us, s1_ul, s1_ns3, s1_nl3, s1_g2ns, s1_g2nl, s1_ns, s1_nl;
  gpor_pkg::q_t s2_wsm, s2_wlm, s2_us, s2_ul, s2_cs, s2_cl, s2_gsn, s2_gln, s2_ns, s2_nl;
  gpor_pkg::q_t s3_cs, s3_cl, s3_xs, s3_xl;
  gpor_pkg::q_t s4_ps, s4_pl;
  gpor_pkg::qres_t r_t1, r_us, r_ul, r_ns3, r_nl3, r_g2ns, r_g2nl;
  gpor_pkg::qres_t r_wsm, r_wlm, r_cs, r_cl, r_gsn, r_gln;
  gpor_pkg::qres_t r_ws, r_wl, r_xs, r_xl, r_ps, r_pl, r_mps, r_mpl;
  gpor_pkg::qres_t r_flux [gpor_pkg::LANES];

  gpor_pkg::qres_t hs, hl;
  gpor_pkg::qres_t r_pr1, r_pr2, r_pr3, r_pr4, r_n1, r_n4;
  gpor_pkg::carry_t p1_c, p2_c, p1_c_next, p2_c_next;
  gpor_pkg::q_t p1_denom, p1_m2ns, p1_m2nl, p1_pr1, p1_pr2, p1_pr3, p1_pr4;
  gpor_pkg::q_t p2_denom, p2_n1, p2_pr2, p2_pr3, p2_n4;

  gpor_pkg::qres_t d1, d2, d3, d4;
  gpor_pkg::q_t z1, z2, z3, z4;
  gpor_pkg::qres_t r_y1, r_y2, r_y3, r_y4;
  gpor_pkg::carry_t e1_c, e2_c, e3_c;
  gpor_pkg::q_t e1_y1, e1_y2, e1_y3, e1_y4, e2_y2, e2_y4;
  gpor_pkg::q_t e2_is, e2_il, e3_is, e3_il;
  logic e1_clip, e2_clip, e3_clip, e1_clip_next;
  gpor_pkg::qres_t r_is2, r_il2, r_is3, r_il3, r_rs, r_rl;
  logic pb_clip;

  assign en = !vs[N-1] || !out_stall;
  assign pop = en && head_valid;
  assign out_valid = vs[N-1];

  gpor_div u_div_hs (.clk(clk), .en(en), .dividend(a.p_ss), .divisor(a.denom), .quo(hs));
  gpor_div u_div_hl (.clk(clk), .en(en), .dividend(a.p_ll), .divisor(a.denom), .quo(hl));
  gpor_div u_div_sns (.clk(clk), .en(en), .dividend(p2_n1), .divisor(p2_denom), .quo(d1));
  gpor_div u_div_lns (.clk(clk), .en(en), .dividend(p2_pr2), .divisor(p2_denom), .quo(d2));
  gpor_div u_div_snl (.clk(clk), .en(en), .dividend(p2_pr3), .divisor(p2_denom), .quo(d3));
  gpor_div u_div_lnl (.clk(clk), .en(en), .dividend(p2_n4), .divisor(p2_denom), .quo(d4));

  always_comb begin
    r_t1 = gpor_pkg::qmul(a.muh, a.mu);
    r_us = gpor_pkg::qmul(a.mu, coeff.solid_ref);
    r_ul = gpor_pkg::qmul(a.mu, coeff.liquid_ref);
    r_ns3 = gpor_pkg::qmul(a.p_ss, a.ns);
    r_nl3 = gpor_pkg::qmul(a.p_ll, a.nl);
    r_g2ns = gpor_pkg::qmul(coeff.g2, a.ns);
    r_g2nl = gpor_pkg::qmul(coeff.g2, a.nl);
    for (int i = 0; i < gpor_pkg::LANES; i++) begin
      if ((i % 3) < DIMENSIONS) begin
        r_flux[i] = gpor_pkg::qmul(coeff.coef, a.grad[i]);
      end else begin
        r_flux[i].val = gpor_pkg::Q_ZERO;
        r_flux[i].clip = 1'b0;
      end
    end
    r_wsm = gpor_pkg::qmul(s1_t1, coeff.inv_solid);
    r_wlm = gpor_pkg::qmul(s1_t1, coeff.inv_liquid);
    r_cs = gpor_pkg::qsub(s1_ns3, s1_ns);
    r_cl = gpor_pkg::qsub(s1_nl3, s1_nl);
    r_gsn = gpor_pkg::qmul(s1_g2ns, s1_nl);
    r_gln = gpor_pkg::qmul(s1_g2nl, s1_ns);
    r_ws = gpor_pkg::qsub(s2_wsm, s2_us);
    r_wl = gpor_pkg::qsub(s2_wlm, s2_ul);
    r_xs = gpor_pkg::qmul(s2_gsn, s2_nl);
    r_xl = gpor_pkg::qmul(s2_gln, s2_ns);
    r_ps = gpor_pkg::qadd(s3_cs, s3_xs);
    r_pl = gpor_pkg::qadd(s3_cl, s3_xl);
    r_mps = gpor_pkg::qmul(coeff.barrier, s4_ps);
    r_mpl = gpor_pkg::qmul(coeff.barrier, s4_pl);

    cv_next[1].ws = gpor_pkg::Q_ZERO;
    cv_next[1].wl = gpor_pkg::Q_ZERO;
    cv_next[1].mps = gpor_pkg::Q_ZERO;
    cv_next[1].mpl = gpor_pkg::Q_ZERO;
    cv_next[1].zero = a.zero;
    cv_next[1].clip_b = a.clip_b;
    cv_next[1].clip_a = a.clip_a | coeff.clip | r_t1.clip | r_us.clip | r_ul.clip
                        | r_ns3.clip | r_nl3.clip | r_g2ns.clip | r_g2nl.clip;
    for (int i = 0; i < gpor_pkg::LANES; i++) begin
      cv_next[1].flux[i] = r_flux[i].val;
      cv_next[1].clip_a = cv_next[1].clip_a | r_flux[i].clip;
    end
    for (int k = 2; k <= DL; k++) begin
      cv_next[k] = cv[k-1];
    end
    cv_next[2].clip_a = cv[1].clip_a | r_wsm.clip | r_wlm.clip | r_cs.clip | r_cl.clip
                        | r_gsn.clip | r_gln.clip;
    cv_next[3].ws = r_ws.val;
    cv_next[3].wl = r_wl.val;
    cv_next[3].clip_a = cv[2].clip_a | r_ws.clip | r_wl.clip | r_xs.clip | r_xl.clip;
    cv_next[4].clip_a = cv[3].clip_a | r_ps.clip | r_pl.clip;
    cv_next[5].mps = r_mps.val;
    cv_next[5].mpl = r_mpl.val;
    cv_next[5].clip_a = cv[4].clip_a | r_mps.clip | r_mpl.clip;
  end

  always_comb begin
    r_pr1 = gpor_pkg::qmul(mv[DL].m2ns, hs.val);
    r_pr2 = gpor_pkg::qmul(mv[DL].mn2ns, hl.val);
    r_pr3 = gpor_pkg::qmul(mv[DL].mn2nl, hs.val);
    r_pr4 = gpor_pkg::qmul(mv[DL].m2nl, hl.val);
    p1_c_next = cv[DL];
    p1_c_next.clip_b = cv[DL].clip_b | hs.clip | hl.clip | r_pr1.clip | r_pr2.clip
                       | r_pr3.clip | r_pr4.clip;
    r_n1 = gpor_pkg::qsub(p1_m2ns, p1_pr1);
    r_n4 = gpor_pkg::qsub(p1_m2nl, p1_pr4);
    p2_c_next = p1_c;
    p2_c_next.clip_b = p1_c.clip_b | r_n1.clip | r_n4.clip;
  end

  always_comb begin
    z1 = ev[DL-1].zero ? gpor_pkg::Q_ZERO : d1.val;
    z2 = ev[DL-1].zero ? gpor_pkg::Q_ZERO : d2.val;
    z3 = ev[DL-1].zero ? gpor_pkg::Q_ZERO : d3.val;
    z4 = ev[DL-1].zero ? gpor_pkg::Q_ZERO : d4.val;
    pb_clip = !ev[DL-1].zero
              && (ev[DL-1].clip_b || d1.clip || d2.clip || d3.clip || d4.clip);
    r_y1 = gpor_pkg::qmul(ev[DL-1].ws, z1);
    r_y2 = gpor_pkg::qmul(ev[DL-1].wl, z2);
    r_y3 = gpor_pkg::qmul(ev[DL-1].ws, z3);
    r_y4 = gpor_pkg::qmul(ev[DL-1].wl, z4);
    e1_clip_next = ev[DL-1].clip_a | pb_clip | r_y1.clip | r_y2.clip | r_y3.clip
                   | r_y4.clip;
    r_is2 = gpor_pkg::qadd(e1_c.mps, e1_y1);
    r_il2 = gpor_pkg::qadd(e1_c.mpl, e1_y3);
    r_is3 = gpor_pkg::qadd(e2_is, e2_y2);
    r_il3 = gpor_pkg::qadd(e2_il, e2_y4);
    r_rs = gpor_pkg::qmul(coeff.neg_l, e3_is);
    r_rl = gpor_pkg::qmul(coeff.neg_l, e3_il);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[N-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a <= head;
      s1_t1 <= r_t1.val;
      s1_us <= r_us.val;
      s1_ul <= r_ul.val;
      s1_ns3 <= r_ns3.val;
      s1_nl3 <= r_nl3.val;
      s1_g2ns <= r_g2ns.val;
      s1_g2nl <= r_g2nl.val;
      s1_ns <= a.ns;
      s1_nl <= a.nl;
      s2_wsm <= r_wsm.val;
      s2_wlm <= r_wlm.val;
      s2_us <= s1_us;
      s2_ul <= s1_ul;
      s2_cs <= r_cs.val;
      s2_cl <= r_cl.val;
      s2_gsn <= r_gsn.val;
      s2_gln <= r_gln.val;
      s2_ns <= s1_ns;
      s2_nl <= s1_nl;
      s3_cs <= s2_cs;
      s3_cl <= s2_cl;
      s3_xs <= r_xs.val;
      s3_xl <= r_xl.val;
      s4_ps <= r_ps.val;
      s4_pl <= r_pl.val;
      for (int k = 1; k <= DL; k++) begin
        cv[k] <= cv_next[k];
      end
      mv[1].m2ns <= a.m2ns;
      mv[1].mn2ns <= a.mn2ns;
      mv[1].m2nl <= a.m2nl;
      mv[1].mn2nl <= a.mn2nl;
      mv[1].denom <= a.denom;
      for (int k = 2; k <= DL; k++) begin
        mv[k] <= mv[k-1];
      end
      p1_c <= p1_c_next;
      p1_denom <= mv[DL].denom;
      p1_m2ns <= mv[DL].m2ns;
      p1_m2nl <= mv[DL].m2nl;
      p1_pr1 <= r_pr1.val;
      p1_pr2 <= r_pr2.val;
      p1_pr3 <= r_pr3.val;
      p1_pr4 <= r_pr4.val;
      p2_c <= p2_c_next;
      p2_denom <= p1_denom;
      p2_n1 <= r_n1.val;
      p2_pr2 <= p1_pr2;
      p2_pr3 <= p1_pr3;
      p2_n4 <= r_n4.val;
      ev[0] <= p2_c;
      for (int k = 1; k < DL; k++) begin
        ev[k] <= ev[k-1];
      end
      e1_c <= ev[DL-1];
      e1_y1 <= r_y1.val;
      e1_y2 <= r_y2.val;
      e1_y3 <= r_y3.val;
      e1_y4 <= r_y4.val;
      e1_clip <= e1_clip_next;
      e2_c <= e1_c;
      e2_is <= r_is2.val;
      e2_il <= r_il2.val;
      e2_y2 <= e1_y2;
      e2_y4 <= e1_y4;
      e2_clip <= e1_clip | r_is2.clip | r_il2.clip;
      e3_c <= e2_c;
      e3_is <= r_is3.val;
      e3_il <= r_il3.val;
      e3_clip <= e2_clip | r_is3.clip | r_il3.clip;
      res.solid_rate <= r_rs.val;
      res.liquid_rate <= r_rl.val;
      res.flux <= e3_c.flux;
      res.zero <= e3_c.zero;
      res.sat <= e3_clip | r_rs.clip | r_rl.clip;
    end
  end

endmodule
